// ===== rtl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the integer to ASCII converter
// Holds the data width, the radix codes, the queued job type and the digit
// to ASCII mapping used by the front and back parts of the block.
// ----------------------------------------------------------------------------
package ita_pkg;

  // Width of the integer being converted.
  localparam int DataWidth = 32;
  // Bits needed to count digits up to DataWidth, and to index the store.
  localparam int CountWidth = $clog2(DataWidth + 1);
  localparam int IndexWidth = $clog2(DataWidth);

  // Reciprocal of ten for a 32-bit dividend: q = (m * DecRecip) >> DecShift.
  localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;
  localparam int          DecShift = 35;

  // Normalised radix of a queued item.
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  // One item handed from the front part to the back part.
  typedef struct packed {
    logic [DataWidth-1:0] mag;
    radix_t               radix;
  } ita_job_t;

  // Status of the queue between the two parts.
  typedef struct packed {
    logic full;
    logic empty;
  } ita_q_stat_t;

  // ASCII code of one digit: '0' to '9', then 'a' to 'f'.
  function automatic logic [6:0] ascii_of(input logic [3:0] d);
    logic [6:0] code;
    if (d < 4'd10) begin
      code = 7'h30 + {3'b000, d};
    end else begin
      code = 7'h61 + {3'b000, d} - 7'd10;
    end
    return code;
  endfunction

endpackage

// ===== rtl/ita_front.sv =====
// ----------------------------------------------------------------------------
// ita_front: item intake and classification
// Holds the radix register, takes the magnitude of each accepted item and
// queues it for conversion. A zero item has no characters and is dropped.
// ----------------------------------------------------------------------------
module ita_front import ita_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 start,
  input  logic [DataWidth-1:0] in_value,
  input  ita_q_stat_t          q_stat,
  output logic                 busy,
  output logic                 push,
  output ita_job_t             push_job
);

  logic [1:0]           radix_select_r;
  logic [1:0]           radix_select_nxt;
  logic [DataWidth-1:0] mag;
  radix_t               radix;

  // Radix register; the user must write it only while the block is idle, the block does not enforce this.
  always_comb begin
    radix_select_nxt = radix_select_r;
    if (cfg_we) begin
      radix_select_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_select_r <= 2'd1;
    end else begin
      radix_select_r <= radix_select_nxt;
    end
  end

  // Bit 1 selects hexadecimal, otherwise bit 0 selects decimal.
  always_comb begin
    if (radix_select_r[1]) begin
      radix = RADIX_HEX;
    end else if (radix_select_r[0]) begin
      radix = RADIX_DEC;
    end else begin
      radix = RADIX_BIN;
    end
  end

  // Magnitude; the most negative value becomes the unsigned top bit alone.
  assign mag = in_value[DataWidth-1] ? (~in_value + 1'b1) : in_value;

  // Accept whenever the queue has room; only non-zero items go forward.
  assign busy          = q_stat.full;
  assign push          = start && !q_stat.full && (mag != '0);
  assign push_job.mag   = mag;
  assign push_job.radix = radix;

endmodule

// ===== rtl/ita_queue.sv =====
// ----------------------------------------------------------------------------
// ita_queue: two-entry item queue
// Decouples intake from conversion so that the front can take items while
// the back part is still converting or emitting the previous one.
// ----------------------------------------------------------------------------
module ita_queue import ita_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ita_job_t    push_job,
  input  logic        pop,
  output ita_job_t    pop_job,
  output ita_q_stat_t q_stat
);

  ita_job_t   entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job      = entry_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

endmodule

// ===== rtl/ita_back.sv =====
// ----------------------------------------------------------------------------
// ita_back: digit extraction and character emission
// Takes queued items, splits the magnitude into digits least significant
// first into a small digit store, then reads them back most significant
// first and emits one character per cycle.
// ----------------------------------------------------------------------------
module ita_back import ita_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ita_q_stat_t q_stat,
  input  ita_job_t    pop_job,
  output logic        pop,
  output logic        out_valid,
  output logic [6:0]  out_digit_char,
  output logic        out_last_char
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIG   = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [DataWidth-1:0]  mag_r;
  logic [DataWidth-1:0]  mag_nxt;
  radix_t                radix_r;
  radix_t                radix_nxt;
  logic [CountWidth-1:0] cnt_r;
  logic [CountWidth-1:0] cnt_nxt;
  logic [IndexWidth-1:0] pos_r;
  logic [IndexWidth-1:0] pos_nxt;
  logic [63:0]           prod_r;
  logic [DataWidth-1:0]  quot;
  logic [DataWidth-1:0]  dec_rem;
  logic [3:0]            digit;
  logic                  wr_en;
  logic [IndexWidth-1:0] rd_addr;
  logic [3:0]            rd_data_r;
  logic [3:0]            digit_mem [DataWidth];

  // Quotient and remainder of one digit step for the current radix.
  always_comb begin
    dec_rem = '0;
    case (radix_r)
      RADIX_DEC: begin
        quot    = DataWidth'(prod_r[63:DecShift]);
        dec_rem = mag_r - (quot << 3) - (quot << 1);
        digit   = dec_rem[3:0];
      end
      RADIX_HEX: begin
        quot  = mag_r >> 4;
        digit = mag_r[3:0];
      end
      RADIX_BIN: begin
        quot  = mag_r >> 1;
        digit = {3'b000, mag_r[0]};
      end
      default: begin
        quot  = mag_r >> 4;
        digit = mag_r[3:0];
      end
    endcase
  end

  // Sequencer: pop, extract digits, then emit them in reverse order.
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    radix_nxt = radix_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          mag_nxt   = pop_job.mag;
          radix_nxt = pop_job.radix;
          cnt_nxt   = '0;
          state_nxt = (pop_job.radix == RADIX_DEC) ? ST_MUL : ST_DIG;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        wr_en   = 1'b1;
        mag_nxt = quot;
        cnt_nxt = cnt_r + 1'b1;
        if (quot == '0) begin
          pos_nxt   = cnt_r[IndexWidth-1:0];
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = (radix_r == RADIX_DEC) ? ST_MUL : ST_DIG;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (pos_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mag_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
    pos_r   <= pos_nxt;
    prod_r  <= 64'(mag_r) * 64'(DecRecip);
  end

  // Digit store: written during extraction, read one entry ahead in emission.
  assign rd_addr = (state_r == ST_EMIT) ? (pos_r - 1'b1) : pos_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt_r[IndexWidth-1:0]] <= digit;
    end
    rd_data_r <= digit_mem[rd_addr];
  end

  // Result strobe and payload.
  assign out_valid      = (state_r == ST_EMIT);
  assign out_digit_char = ascii_of(rd_data_r);
  assign out_last_char  = (pos_r == '0);

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: signed integer to ASCII digit string
// Converts the magnitude of a 32-bit signed integer into binary, decimal or
// lower-case hexadecimal characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we with cfg_wdata writes the radix register (0 binary,
//   1 decimal, 2 or 3 hexadecimal). Write it only while no item is in flight.
//   Input: an item is taken at a clock edge with start high and busy low.
//   busy is high while the two-entry queue in front of the converter is full.
//   Output: each character is shown for one cycle with out_valid high;
//   out_last_char marks the final character. The receiver cannot stall.
//   A zero item produces no characters and uses no conversion time.
// Steps per item in the back part:
//   decimal: a reciprocal multiply, then a fix-up, for each digit;
//   binary and hexadecimal: a shift for each digit.
//   The longest item is a binary number of 32 digits. The first character
//   appears after the last digit step and a fetch from the digit store.
// Reset: rst_n is synchronous, active low; the radix returns to decimal and
//   the queue and sequencer are emptied.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii import ita_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [DataWidth-1:0] in_value,
  output logic                 out_valid,
  output logic [6:0]           out_digit_char,
  output logic                 out_last_char
);

  ita_q_stat_t q_stat;
  ita_job_t    push_job;
  ita_job_t    pop_job;
  logic        push;
  logic        pop;

  // Intake and classification.
  ita_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_value  (in_value),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_job  (push_job)
  );

  // Queue between the two parts.
  ita_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // Conversion and emission.
  ita_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_job        (pop_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_char  (out_last_char)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for integer_to_radix_ascii
// Feeds signed integers through the start/busy handshake under every radix
// setting and predicts the ASCII digit string of each magnitude. A small
// scoreboard holds the characters still to come and checks each strobed
// output character, and its last-character flag, against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import ita_pkg::*;

  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam int         SettleCycles = 160;

  // Radix register codes as written on the configuration port.
  localparam logic [1:0] SelBin    = 2'd0;
  localparam logic [1:0] SelDec    = 2'd1;
  localparam logic [1:0] SelHex    = 2'd2;
  localparam logic [1:0] SelHexAlt = 2'd3;

  // One expected character of the output string.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } digit_char_t;

  // Scoreboard: predicts the digit string of each accepted item and checks
  // the characters as they leave the block.
  class digit_string_board;
    digit_char_t pending_chars[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction

    // Work out the characters of one accepted item under the given radix.
    function void note_value(logic [DataWidth-1:0] value, logic [1:0] sel);
      radix_t               rdx;
      logic [DataWidth-1:0] mag;
      logic [DataWidth-1:0] base;
      logic [3:0]           digits[DataWidth];
      int                   n;
      digit_char_t          c;
      rdx  = sel[1] ? RADIX_HEX : (sel[0] ? RADIX_DEC : RADIX_BIN);
      case (rdx)
        RADIX_BIN: base = 2;
        RADIX_DEC: base = 10;
        default:   base = 16;
      endcase
      // The most negative value negates to itself, which is 2^31 unsigned.
      mag = value[DataWidth-1] ? (~value + 1'b1) : value;
      n   = 0;
      while (mag != 0 && n < DataWidth) begin
        digits[n] = 4'(mag % base);
        mag       = mag / base;
        n++;
      end
      // Most significant digit first; a zero item leaves nothing to expect.
      for (int k = n - 1; k >= 0; k--) begin
        c.code = (digits[k] < 4'd10) ? CharZero + 7'(digits[k])
                                     : CharLowerA + 7'(digits[k]) - 7'd10;
        c.last = (k == 0);
        pending_chars.insert(pending_chars.size(), c);
      end
    endfunction

    // Compare one output character with the oldest expectation.
    function void check_char(logic [6:0] code, logic last);
      digit_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h (last %b)", $time, code, last);
        mismatches++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code) begin
        $display("%0t: digit_char mismatch, expected %h got %h",
                 $time, exp_c.code, code);
        mismatches++;
      end
      if (last !== exp_c.last) begin
        $display("%0t: last_char mismatch, expected %b got %b",
                 $time, exp_c.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [1:0]           cfg_wdata = '0;
  logic                 start     = 1'b0;
  logic [DataWidth-1:0] in_value  = '0;
  logic                 busy;
  logic                 out_valid;
  logic [6:0]           out_digit_char;
  logic                 out_last_char;

  digit_string_board board = new();
  logic [1:0]        radix_now = SelDec;
  bit                burst = 1'b0;

  integer_to_radix_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_char  (out_last_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_value(in_value, radix_now);
      end
      if (out_valid) begin
        board.check_char(out_digit_char, out_last_char);
      end
    end
  end

  // Idle cycles before an item: mostly short, now and then long, none in a burst.
  function automatic int idle_gap();
    int pick;
    if (burst) begin
      return 0;
    end
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      return 0;
    end else if (pick < 17) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  // Random value: zeros, extremes, short and long magnitudes of either sign.
  function automatic logic [DataWidth-1:0] random_value();
    logic [DataWidth-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2, 3: v = $urandom_range(1, 300);
      4, 5: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v != 32'h8000_0000) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // Offer one item and hold it until the block takes it. Called at a rising edge.
  task automatic send_value(input logic [DataWidth-1:0] v);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      send_value(random_value());
    end
    burst = 1'b0;
  endtask

  // Let every expected character out, then leave the block idle to settle.
  task automatic drain();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_radix(input logic [1:0] sel);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_now = sel;
  endtask

  logic [DataWidth-1:0] dec_cases[9] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
    32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000
  };
  logic [DataWidth-1:0] bin_cases[5] = '{
    32'd1, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
  };
  logic [DataWidth-1:0] hex_cases[6] = '{
    32'd15, 32'd16, 32'h0ABC_DEF0, 32'h8000_0000, 32'hFFFF_FFF1, 32'd0
  };
  logic [DataWidth-1:0] alt_cases[3] = '{
    32'h7FFF_FFFF, 32'd255, 32'hFFFF_FF01
  };

  // Main sequence: decimal out of reset, then binary, both hex codes, decimal.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dec_cases[i]) send_value(dec_cases[i]);
    send_random(60);
    drain();

    write_radix(SelBin);
    foreach (bin_cases[i]) send_value(bin_cases[i]);
    send_random(50);
    drain();

    write_radix(SelHex);
    foreach (hex_cases[i]) send_value(hex_cases[i]);
    send_random(60);
    drain();

    write_radix(SelHexAlt);
    foreach (alt_cases[i]) send_value(alt_cases[i]);
    send_random(50);
    drain();

    write_radix(SelDec);
    send_random(60);
    drain();

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ita_pkg.sv
rtl/ita_front.sv
rtl/ita_queue.sv
rtl/ita_back.sv
rtl/integer_to_radix_ascii.sv
dv/testbench.sv
